// ===== sv/epsc_pkg.sv =====
package epsc_pkg;

  // Field types shared across the pipeline.
  typedef logic [30:0] epoch_sec_t;   // seconds since the epoch
  typedef logic [14:0] day_cnt_t;     // whole days, also days counted from 1968-01-01
  typedef logic [10:0] year_t;        // Gregorian year
  typedef logic [3:0]  month_t;       // month of year, 1 = January
  typedef logic [4:0]  mday_t;        // zero-based day of month
  typedef logic [8:0]  yday_t;        // zero-based day of year

  // One day is 86400 s = 2^7 * 675 s. The factor 675 is divided out by a
  // reciprocal multiply, which gives the exact quotient or one less.
  localparam logic [24:0] DIV675_MUL   = 25'd25451658;  // floor(2^34 / 675)
  localparam logic [9:0]  SEC_GROUP    = 10'd675;

  // Four-year cycles starting with the leap year 1968. The plain rule of one
  // leap year in four holds from 1901 to 2099, which covers every input.
  localparam logic [19:0] DIV1461_MUL  = 20'd734936;    // floor(2^30 / 1461)
  localparam logic [10:0] CYCLE_DAYS   = 11'd1461;
  localparam day_cnt_t    DAYS_BEFORE_EPOCH = 15'd731;  // 1968 and 1969
  localparam year_t       CYCLE_BASE_YEAR   = 11'd1968;

  localparam logic [10:0] CYC_YEAR1_DAY = 11'd366;
  localparam logic [10:0] CYC_YEAR2_DAY = 11'd731;
  localparam logic [10:0] CYC_YEAR3_DAY = 11'd1096;

endpackage

// ===== sv/epsc_days.sv =====
// Seconds to whole days, counted from 1968-01-01. Three register stages.
module epsc_days import epsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  epoch_sec_t in_secs,
  output logic       out_valid,
  input  logic       out_ready,
  output day_cnt_t   out_days
);

  logic        v1_r, v2_r, v3_r;
  logic        en1, en2, en3;

  logic [23:0] s1_x_r;
  logic [48:0] s1_prod_r;
  logic [23:0] s2_x_r;
  logic [14:0] s2_q_r;
  logic [24:0] s2_qm_r;
  day_cnt_t    s3_days_r;

  logic [14:0] q_est;
  logic [23:0] rem;
  day_cnt_t    days_nxt;

  assign en3      = !v3_r || out_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign q_est = s1_prod_r[48:34];

  // The estimate is short by at most one group of 675.
  always_comb begin
    rem      = s2_x_r - s2_qm_r[23:0];
    days_nxt = s2_q_r + DAYS_BEFORE_EPOCH;
    if (rem >= 24'(SEC_GROUP)) begin
      days_nxt = s2_q_r + DAYS_BEFORE_EPOCH + 15'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_x_r    <= in_secs[30:7];
      s1_prod_r <= 49'(in_secs[30:7]) * 49'(DIV675_MUL);
    end
    if (en2) begin
      s2_x_r  <= s1_x_r;
      s2_q_r  <= q_est;
      s2_qm_r <= 25'(q_est) * 25'(SEC_GROUP);
    end
    if (en3) begin
      s3_days_r <= days_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_days  = s3_days_r;

endmodule

// ===== sv/epsc_year.sv =====
// Days from 1968-01-01 to year, day of year and leap flag. Four register stages.
module epsc_year import epsc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  day_cnt_t in_days,
  output logic     out_valid,
  input  logic     out_ready,
  output year_t    out_year,
  output yday_t    out_yday,
  output logic     out_leap
);

  logic        v1_r, v2_r, v3_r, v4_r;
  logic        en1, en2, en3, en4;

  day_cnt_t    s1_d_r;
  logic [34:0] s1_prod_r;
  day_cnt_t    s2_d_r;
  logic [4:0]  s2_c_r;
  day_cnt_t    s2_cm_r;
  logic [4:0]  s3_c_r;
  logic [10:0] s3_rem_r;
  year_t       s4_year_r;
  yday_t       s4_yday_r;
  logic        s4_leap_r;

  logic [4:0]  c_est;
  day_cnt_t    rem_raw;
  logic [4:0]  c_nxt;
  logic [10:0] rem_nxt;
  logic [1:0]  yo;
  logic [10:0] yday_wide;

  assign en4      = !v4_r || out_ready;
  assign en3      = !v3_r || en4;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  assign c_est = s1_prod_r[34:30];

  // Correct the cycle estimate, which may be one short.
  always_comb begin
    rem_raw = s2_d_r - s2_cm_r;
    c_nxt   = s2_c_r;
    rem_nxt = rem_raw[10:0];
    if (rem_raw >= 15'(CYCLE_DAYS)) begin
      c_nxt   = s2_c_r + 5'd1;
      rem_nxt = rem_raw[10:0] - CYCLE_DAYS;
    end
  end

  // Place the day within its four-year cycle; the first year is the leap one.
  always_comb begin
    if (s3_rem_r < CYC_YEAR1_DAY) begin
      yo        = 2'd0;
      yday_wide = s3_rem_r;
    end else if (s3_rem_r < CYC_YEAR2_DAY) begin
      yo        = 2'd1;
      yday_wide = s3_rem_r - CYC_YEAR1_DAY;
    end else if (s3_rem_r < CYC_YEAR3_DAY) begin
      yo        = 2'd2;
      yday_wide = s3_rem_r - CYC_YEAR2_DAY;
    end else begin
      yo        = 2'd3;
      yday_wide = s3_rem_r - CYC_YEAR3_DAY;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_d_r    <= in_days;
      s1_prod_r <= 35'(in_days) * 35'(DIV1461_MUL);
    end
    if (en2) begin
      s2_d_r  <= s1_d_r;
      s2_c_r  <= c_est;
      s2_cm_r <= 15'(c_est) * 15'(CYCLE_DAYS);
    end
    if (en3) begin
      s3_c_r   <= c_nxt;
      s3_rem_r <= rem_nxt;
    end
    if (en4) begin
      s4_year_r <= CYCLE_BASE_YEAR + {4'd0, s3_c_r, 2'd0} + {9'd0, yo};
      s4_yday_r <= yday_wide[8:0];
      s4_leap_r <= (yo == 2'd0);
    end
  end

  assign out_valid = v4_r;
  assign out_year  = s4_year_r;
  assign out_yday  = s4_yday_r;
  assign out_leap  = s4_leap_r;

endmodule

// ===== sv/epsc_month.sv =====
// Day of year to month and day of month; this stage is the output register.
module epsc_month import epsc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  year_t  in_year,
  input  yday_t  in_yday,
  input  logic   in_leap,
  output logic   out_valid,
  input  logic   out_ready,
  output year_t  out_year,
  output month_t out_month,
  output mday_t  out_mday
);

  logic   v_r;
  logic   en;
  year_t  year_r;
  month_t month_r;
  mday_t  mday_r;

  month_t month_nxt;
  yday_t  first_day;
  yday_t  mday_wide;

  function automatic yday_t month_first_day(month_t m, logic leap);
    yday_t base;
    case (m)
      4'd1:    base = 9'd0;
      4'd2:    base = 9'd31;
      4'd3:    base = 9'd59;
      4'd4:    base = 9'd90;
      4'd5:    base = 9'd120;
      4'd6:    base = 9'd151;
      4'd7:    base = 9'd181;
      4'd8:    base = 9'd212;
      4'd9:    base = 9'd243;
      4'd10:   base = 9'd273;
      4'd11:   base = 9'd304;
      4'd12:   base = 9'd334;
      default: base = 9'd0;
    endcase
    if (leap && m >= 4'd3) begin
      base = base + 9'd1;
    end
    return base;
  endfunction

  // Eleven independent compares against the starts of February to December; the last hit wins.
  always_comb begin
    month_nxt = 4'd1;
    for (int m = 2; m <= 12; m++) begin
      if (in_yday >= month_first_day(4'(m), in_leap)) begin
        month_nxt = 4'(m);
      end
    end
    first_day = month_first_day(month_nxt, in_leap);
    mday_wide = in_yday - first_day;
  end

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      year_r  <= in_year;
      month_r <= month_nxt;
      mday_r  <= mday_wide[4:0];
    end
  end

  assign out_valid = v_r;
  assign out_year  = year_r;
  assign out_month = month_r;
  assign out_mday  = mday_r;

endmodule

// ===== sv/epoch_seconds_to_civil_date.sv =====
// Channel   Direction  Ports                              Payload
// in_       slave      in_tvalid, in_tready, in_tdata     epoch_seconds (31 bits)
// out_      master     out_tvalid, out_tready, out_tdata  civil_year, civil_month,
//                                                         day_in_month
//
// One transfer in gives one transfer out, after it has passed the eight register
// stages of the pipeline. A new item may enter in every cycle while out_tready does
// not stall the pipeline, so the sustained rate is then one item per clock.
// Reset clears only the stage valid bits; data registers carry no reset.
// Every stage loads when it is empty or when the stage after it moves, so a stall on
// out_tready holds the full stages in place and lets bubbles close up; nothing is
// dropped or sent twice.
module epoch_seconds_to_civil_date import epsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [30:0] epoch_seconds, [31] zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata    // [10:0] civil_year, [14:11] civil_month,
                                   // [19:15] day_in_month, [23:20] zero fill
);

  // Handshakes between the three sections of the pipeline.
  logic     days_valid, days_ready;
  day_cnt_t days;

  logic     ydate_valid, ydate_ready;
  year_t    ydate_year;
  yday_t    ydate_yday;
  logic     ydate_leap;

  year_t    res_year;
  month_t   res_month;
  mday_t    res_mday;

  // Stages 1 to 3: divide the seconds down to days and rebase them to 1968-01-01.
  epsc_days u_days (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_secs   (in_tdata[30:0]),
    .out_valid (days_valid),
    .out_ready (days_ready),
    .out_days  (days)
  );

  // Stages 4 to 7: split the days into four-year cycles, then into the year and
  // the day within that year.
  epsc_year u_year (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (days_valid),
    .in_ready  (days_ready),
    .in_days   (days),
    .out_valid (ydate_valid),
    .out_ready (ydate_ready),
    .out_year  (ydate_year),
    .out_yday  (ydate_yday),
    .out_leap  (ydate_leap)
  );

  // Stage 8: pick the month from the day of year; this register drives the output.
  epsc_month u_month (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (ydate_valid),
    .in_ready  (ydate_ready),
    .in_year   (ydate_year),
    .in_yday   (ydate_yday),
    .in_leap   (ydate_leap),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_year  (res_year),
    .out_month (res_month),
    .out_mday  (res_mday)
  );

  assign out_tdata = {4'd0, res_mday, res_month, res_year};

endmodule

// ===== tb/epoch_date_checker.sv =====
module epoch_date_checker import epsc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  output int          mismatch_count,
  output int          pending_dates,
  output int          dates_compared
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SECS_PER_DAY = 60 * 60 * 24;
  localparam int          REPORT_LIMIT = 10;

  typedef struct {
    year_t  year;
    month_t month;
    mday_t  mday;
  } civil_date_t;

  civil_date_t expected_dates[$];

  function automatic bit is_leap(int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int unsigned month_days(int unsigned yr, int unsigned mon);
    case (mon)
      4, 6, 9, 11: return 30;
      2:           return is_leap(yr) ? 29 : 28;
      default:     return 31;
    endcase
  endfunction

  // Walk whole years from 1970, then whole months, and keep the remainder.
  function automatic civil_date_t civil_from_seconds(epoch_sec_t secs);
    int unsigned days_left;
    int unsigned yr;
    int unsigned mon;
    civil_date_t d;
    days_left = secs / SECS_PER_DAY;
    yr = 1970;
    while (days_left >= (is_leap(yr) ? 366 : 365)) begin
      days_left -= is_leap(yr) ? 366 : 365;
      yr++;
    end
    mon = 1;
    while (mon < 12 && days_left >= month_days(yr, mon)) begin
      days_left -= month_days(yr, mon);
      mon++;
    end
    d.year  = year_t'(yr);
    d.month = month_t'(mon);
    d.mday  = mday_t'(days_left);
    return d;
  endfunction

  always @(posedge clk) begin
    civil_date_t want;
    year_t       got_year;
    month_t      got_month;
    mday_t       got_mday;
    got_year  = out_tdata[10:0];
    got_month = out_tdata[14:11];
    got_mday  = out_tdata[19:15];
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_dates.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("%0t: unexpected date out: year %0d month %0d day %0d", $realtime,
                     got_year, got_month, got_mday);
          mismatch_count <= mismatch_count + 1;
        end else begin
          want = expected_dates.pop_front();
          if (got_year !== want.year || got_month !== want.month || got_mday !== want.mday)
          begin
            if (mismatch_count < REPORT_LIMIT)
              $display("%0t: date mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                       $realtime, want.year, want.month, want.mday,
                       got_year, got_month, got_mday);
            mismatch_count <= mismatch_count + 1;
          end
          dates_compared <= dates_compared + 1;
        end
      end
      if (in_tvalid && in_tready)
        expected_dates.push_back(civil_from_seconds(in_tdata[30:0]));
    end
    pending_dates <= expected_dates.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  import epsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // Stimulus sizes and timing limits.
  localparam int          RANDOM_ITEMS  = 1275;
  localparam int          STALL_LIMIT   = 2000;  // quiet cycles before the run is abandoned
  localparam int          LONG_HOLD     = 300;   // receiver hold-off, far beyond the pipe depth
  localparam int          HOLD_AT_ITEM  = 600;   // input count at which the hold-off starts
  localparam int          DRAIN_CYCLES  = 20;    // settle time after the last result
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned LAST_SECOND   = 32'h7FFF_FFFF;
  localparam int unsigned LAST_DAY      = LAST_SECOND / SECS_PER_DAY;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata   = '0;   // [30:0] epoch_seconds, [31] zero fill
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;         // [10:0] civil_year, [14:11] civil_month,
                                  // [19:15] day_in_month, [23:20] zero fill

  int mismatch_count;
  int pending_dates;
  int dates_compared;
  int stamps_sent  = 0;  // input transfers seen so far
  int quiet_cycles = 0;

  epoch_seconds_to_civil_date DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // The checker sees both channels, predicts each date and compares it.
  epoch_date_checker date_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .pending_dates  (pending_dates),
    .dates_compared (dates_compared)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Most gaps are zero or a few cycles; now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one timestamp after an optional idle gap and hold it until the block
  // takes the transfer. The task returns at the edge where it was accepted, so
  // the next call may keep in_tvalid high without a glitch.
  task automatic send_seconds(epoch_sec_t secs, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, secs};
    do @(posedge clk); while (!in_tready);
  endtask

  // Count input transfers for pacing, and watch for a hung pipeline: any
  // transfer on either side restarts the quiet counter.
  always @(posedge clk) begin
    if (in_tvalid && in_tready) stamps_sent <= stamps_sent + 1;
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d dates still pending",
               $realtime, STALL_LIMIT, pending_dates);
      $display("tb failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver. It stalls at random, holds off once for a long stretch so that
  // the pipeline fills and pushes back on the input, and stays ready for a
  // while later on so that back-to-back transfers are also seen.
  initial begin
    int  gap;
    bit  held_off;
    held_off = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!held_off && stamps_sent >= HOLD_AT_ITEM) begin
        held_off = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        gap = pick_gap();
        if (stamps_sent >= 900 && stamps_sent < 1000) gap = 0;
        if (gap > 0) begin
          out_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(6, 1)) @(posedge clk);
      end
    end
  end

  // Sender and verdict.
  initial begin
    // Day numbers since the epoch that sit on month and year edges: the first and
    // last days of February 1970 and the day after, the turn of 1970/1971, the
    // leap day of 1972 and the day after it, the turn of 1972/1973, the turn of the
    // century, the leap day of 2000 (a year divisible by 400), the end of 2000, the
    // start of 2038 and the last day the 31-bit count reaches.
    int unsigned edge_days[$];
    int unsigned corner_secs[$];
    longint unsigned stamp;
    int          day;
    int          r;
    int          gap;
    edge_days = '{31, 58, 59, 364, 365, 789, 790, 1095, 1096, 10956, 10957,
                  11016, 11017, 11322, 11323, 24837, LAST_DAY};

    // Directed part: the first seconds of the epoch and the edges of the first
    // day, the start of each edge day above, the largest count, and two
    // alternating bit patterns.
    corner_secs = '{0, 1, 59, 60, SECS_PER_DAY - 1, SECS_PER_DAY,
                    LAST_SECOND, 32'h5555_5555 & LAST_SECOND,
                    32'h2AAA_AAAA & LAST_SECOND};
    foreach (edge_days[i]) corner_secs.push_back(edge_days[i] * SECS_PER_DAY);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_secs[i]) send_seconds(epoch_sec_t'(corner_secs[i]), pick_gap());

    // Random part. Three in ten are raw 31-bit counts, the rest land on the first,
    // the last or a random second of a day, either anywhere in range or a few days
    // around one of the edge days, where the year and month walk turns over.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      r = $urandom_range(99);
      if (r < 30) begin
        stamp = $urandom & LAST_SECOND;
      end else begin
        if (r < 75) day = $urandom_range(LAST_DAY);
        else day = edge_days[$urandom_range(edge_days.size() - 1)] + $urandom_range(6) - 3;
        stamp = longint'(day) * SECS_PER_DAY;
        case ($urandom_range(2))
          0:       stamp = stamp;
          1:       stamp = stamp + SECS_PER_DAY - 1;
          default: stamp = stamp + $urandom_range(SECS_PER_DAY - 1);
        endcase
        if (stamp > LAST_SECOND) stamp = LAST_SECOND;
      end
      // Offer items without a break around the receiver's long hold-off so that
      // the input side is seen to stall, and in a few other windows as well.
      gap = pick_gap();
      if ((stamps_sent >= HOLD_AT_ITEM - 20 && stamps_sent < HOLD_AT_ITEM + 160) ||
          (n % 250 < 30))
        gap = 0;
      send_seconds(epoch_sec_t'(stamp), gap);
    end
    in_tvalid <= 1'b0;

    // The checker's pending count is registered, so wait before reading it.
    @(posedge clk);

    // Wait for the last date to come out; the watchdog bounds this wait.
    while (pending_dates != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d timestamps, %0d dates compared, %0d mismatches.",
             stamps_sent, dates_compared, mismatch_count);
    $display("Covered day edges, year ends, leap days in 1972 and 2000, the top count.");
    if (mismatch_count == 0 && pending_dates == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// ===== epoch_seconds_to_civil_date.f =====
sv/epsc_pkg.sv
sv/epsc_days.sv
sv/epsc_year.sv
sv/epsc_month.sv
sv/epoch_seconds_to_civil_date.sv
tb/epoch_date_checker.sv
tb/tb.sv
